@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Depends on nothing; guarded against double inclusion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/core/pfe_pkg.sv @@
// Package of the postfix evaluator: widths, status codes, state type and ALU control types.
// Depends on nothing.
package pfe_pkg;
  localparam int unsigned StackDepth = 64;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned FracBits = ValueWidth / 2;
  localparam int unsigned PtrWidth = $clog2(StackDepth);
  localparam int unsigned CntWidth = $clog2(StackDepth + 1);
  localparam int unsigned CycWidth = $clog2(2 * ValueWidth + 1);

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StUnder   = 3'd1;
  localparam logic [2:0] StBadChar = 3'd2;
  localparam logic [2:0] StFull    = 3'd3;
  localparam logic [2:0] StDivZero = 3'd4;
  localparam logic [2:0] StNegExp  = 3'd5;

  typedef enum logic [1:0] {
    AluMul,
    AluDiv
  } alu_op_e;

  typedef enum logic [3:0] {
    SIdle,
    SRead1,
    SRead2,
    SOp,
    SPowMul,
    SPowWait,
    SPowSq,
    SPowSqWait,
    SAluWait,
    SPush,
    SLast,
    SLastRd,
    SOut
  } state_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_ctl_t;
endpackage

@@ rtl/core/pfe_alu.sv @@
// Shared multi-cycle multiply and divide unit for signed fixed-point values.
// Depends on pfe_pkg.
module pfe_alu (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pfe_pkg::alu_ctl_t                  ctl_i,
  input  logic signed [pfe_pkg::ValueWidth-1:0] a_i,
  input  logic signed [pfe_pkg::ValueWidth-1:0] b_i,
  output logic                               done_o,
  output logic signed [pfe_pkg::ValueWidth-1:0] res_o
);
  localparam int unsigned W = pfe_pkg::ValueWidth;
  localparam int unsigned NW = 2 * W;

  logic              busy_q, busy_d;
  logic              div_q, div_d;
  logic              neg_q, neg_d;
  logic [pfe_pkg::CycWidth-1:0] cnt_q, cnt_d;
  logic [NW-1:0]     acc_q, acc_d;
  logic [NW-1:0]     sh_q, sh_d;
  logic [W-1:0]      mb_q, mb_d;
  logic [W:0]        rem_q, rem_d;
  logic              done_q, done_d;
  logic signed [W-1:0] res_q, res_d;
  logic [W-1:0]      ma, mbv;
  logic [W:0]        rem_sh;
  logic [NW-1:0]     mag;
  logic [W-1:0]      lim;

  assign ma = a_i[W-1] ? W'(-a_i) : W'(a_i);
  assign mbv = b_i[W-1] ? W'(-b_i) : W'(b_i);
  assign rem_sh = {rem_q[W-1:0], sh_q[NW-1]};

  always_comb begin
    busy_d = busy_q;
    div_d = div_q;
    neg_d = neg_q;
    cnt_d = cnt_q;
    acc_d = acc_q;
    sh_d = sh_q;
    mb_d = mb_q;
    rem_d = rem_q;
    done_d = 1'b0;
    res_d = res_q;
    mag = div_q ? acc_q : (acc_q >> pfe_pkg::FracBits);
    lim = neg_q ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    if (ctl_i.start) begin
      busy_d = 1'b1;
      div_d = (ctl_i.op == pfe_pkg::AluDiv);
      neg_d = a_i[W-1] ^ b_i[W-1];
      acc_d = '0;
      rem_d = '0;
      mb_d = mbv;
      if (ctl_i.op == pfe_pkg::AluDiv) begin
        sh_d = NW'(ma) << pfe_pkg::FracBits;
        cnt_d = pfe_pkg::CycWidth'(NW);
      end else begin
        sh_d = NW'(ma);
        cnt_d = pfe_pkg::CycWidth'(W);
      end
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (mag > NW'(lim)) begin
          res_d = neg_q ? $signed(lim) : $signed(lim);
        end else begin
          res_d = neg_q ? $signed(W'(-mag[W-1:0])) : $signed(mag[W-1:0]);
        end
      end else begin
        cnt_d = cnt_q - 1'b1;
        if (div_q) begin
          sh_d = sh_q << 1;
          if (rem_sh >= {1'b0, mb_q}) begin
            rem_d = rem_sh - {1'b0, mb_q};
            acc_d = {acc_q[NW-2:0], 1'b1};
          end else begin
            rem_d = rem_sh;
            acc_d = {acc_q[NW-2:0], 1'b0};
          end
        end else begin
          sh_d = sh_q << 1;
          mb_d = mb_q >> 1;
          if (mb_q[0]) begin
            acc_d = acc_q + sh_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    neg_q <= neg_d;
    cnt_q <= cnt_d;
    acc_q <= acc_d;
    sh_q <= sh_d;
    mb_q <= mb_d;
    rem_q <= rem_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o = res_q;
endmodule

@@ rtl/core/postfix_expression_evaluator.sv @@
// Top level of the postfix expression evaluator.
// Depends on pfe_pkg and pfe_alu.
//
// The input channel takes one ASCII character per word together with a
// Q16.16 variable value and a last flag. Digits and letters push, space and
// newline are skipped, and ^ * / + - pop two operands and push the result.
// The output channel carries one word per expression, after the word
// marked last: the top of the stack and a status code.
// Multiply and divide share one unit, which multiplies by shift-and-add and
// divides by shift-and-subtract. A power takes one multiply per set exponent
// bit and one squaring per further bit. The stack is a 64-entry memory with a
// registered read port; the two operands are read one after the other. A word
// marked last passes through the SLastRd and SOut states, and its result is
// registered onto the output channel in SOut.
// Reset clears the stack count and the pending error; stack contents are
// not cleared. A result waiting on a stalled receiver does not block the
// input; the block stalls only when the next result is ready before the
// waiting one is taken.
module postfix_expression_evaluator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [7:0]  symbol_i,
  input  logic signed [31:0] variable_value_i,
  input  logic        last_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic signed [31:0] result_value_o,
  output logic [2:0]  status_o
);
  localparam int unsigned W = pfe_pkg::ValueWidth;
  localparam int unsigned PW = pfe_pkg::PtrWidth;
  localparam int unsigned CW = pfe_pkg::CntWidth;
  localparam int unsigned FracBitsW = pfe_pkg::FracBits;

  pfe_pkg::state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [2:0]    err_q, err_d;
  logic [7:0]    sym_q, sym_d;
  logic          last_q, last_d;
  logic [W-1:0]  var_q, var_d;
  logic [W-1:0]  l_q, l_d, r_q, r_d;
  logic [W-1:0]  base_q, base_d, acc_q, acc_d;
  logic [W-FracBitsW-1:0] exp_q, exp_d;
  logic [W-1:0]  pv_q, pv_d;
  logic          vo_q, vo_d;
  logic [31:0]   ov_q, ov_d;
  logic [2:0]    os_q, os_d;

  logic [W-1:0]  mem [pfe_pkg::StackDepth];
  logic [W-1:0]  rd_q;
  logic          we;
  logic [PW-1:0] wa, ra;

  pfe_pkg::alu_ctl_t alu_ctl;
  logic signed [W-1:0] alu_a, alu_b, alu_res;
  logic          alu_done;
  logic [W-1:0]  rmag;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= pv_d;
    end
    rd_q <= mem[ra];
  end

  pfe_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (alu_ctl),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  assign rmag = r_q[W-1] ? W'(-r_q) : r_q;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    err_d = err_q;
    sym_d = sym_q;
    last_d = last_q;
    var_d = var_q;
    l_d = l_q;
    r_d = r_q;
    base_d = base_q;
    acc_d = acc_q;
    exp_d = exp_q;
    pv_d = pv_q;
    vo_d = vo_q;
    ov_d = ov_q;
    os_d = os_q;
    we = 1'b0;
    wa = cnt_q[PW-1:0];
    ra = PW'(cnt_q - 1'b1);
    alu_ctl.start = 1'b0;
    alu_ctl.op = pfe_pkg::AluMul;
    alu_a = $signed(l_q);
    alu_b = $signed(r_q);
    ready_o = 1'b0;
    if (vo_q && ready_i) begin
      vo_d = 1'b0;
    end
    case (state_q)
      pfe_pkg::SIdle: begin
        ready_o = 1'b1;
        if (valid_i) begin
          sym_d = symbol_i;
          var_d = W'(variable_value_i);
          last_d = last_i;
          state_d = pfe_pkg::SLast;
          if (err_q == pfe_pkg::StOk) begin
            if (symbol_i inside {[8'h30:8'h39]}) begin
              pv_d = W'(symbol_i - 8'h30) << FracBitsW;
              state_d = pfe_pkg::SPush;
            end else if (symbol_i inside {[8'h41:8'h5a], [8'h61:8'h7a]}) begin
              pv_d = W'(variable_value_i);
              state_d = pfe_pkg::SPush;
            end else if (symbol_i inside {8'h20, 8'h0a}) begin
              state_d = pfe_pkg::SLast;
            end else if (symbol_i inside {8'h5e, 8'h2a, 8'h2f, 8'h2b, 8'h2d}) begin
              if (cnt_q < CW'(2)) begin
                err_d = pfe_pkg::StUnder;
              end else begin
                state_d = pfe_pkg::SRead1;
              end
            end else begin
              err_d = pfe_pkg::StBadChar;
            end
          end
        end
      end
      pfe_pkg::SRead1: begin
        r_d = rd_q;
        ra = PW'(cnt_q - CW'(2));
        state_d = pfe_pkg::SRead2;
      end
      pfe_pkg::SRead2: begin
        l_d = rd_q;
        state_d = pfe_pkg::SOp;
      end
      pfe_pkg::SOp: begin
        cnt_d = cnt_q - CW'(2);
        state_d = pfe_pkg::SLast;
        case (sym_q)
          8'h2b: begin
            pv_d = l_d + r_q;
            if (l_d[W-1] == r_q[W-1] && pv_d[W-1] != l_d[W-1]) begin
              pv_d = l_d[W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end
            state_d = pfe_pkg::SPush;
          end
          8'h2d: begin
            pv_d = l_d - r_q;
            if (l_d[W-1] != r_q[W-1] && pv_d[W-1] != l_d[W-1]) begin
              pv_d = l_d[W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end
            state_d = pfe_pkg::SPush;
          end
          8'h2a: begin
            alu_ctl.start = 1'b1;
            alu_a = $signed(l_d);
            state_d = pfe_pkg::SAluWait;
          end
          8'h2f: begin
            if (r_q == '0) begin
              err_d = pfe_pkg::StDivZero;
            end else begin
              alu_ctl.start = 1'b1;
              alu_ctl.op = pfe_pkg::AluDiv;
              alu_a = $signed(l_d);
              state_d = pfe_pkg::SAluWait;
            end
          end
          default: begin
            exp_d = rmag[W-1:FracBitsW];
            if (r_q[W-1] && rmag[W-1:FracBitsW] != '0) begin
              err_d = pfe_pkg::StNegExp;
            end else begin
              base_d = l_d;
              acc_d = W'(1) << FracBitsW;
              state_d = pfe_pkg::SPowMul;
            end
          end
        endcase
      end
      pfe_pkg::SPowMul: begin
        if (exp_q == '0) begin
          pv_d = acc_q;
          state_d = pfe_pkg::SPush;
        end else if (exp_q[0]) begin
          alu_ctl.start = 1'b1;
          alu_a = $signed(acc_q);
          alu_b = $signed(base_q);
          state_d = pfe_pkg::SPowWait;
        end else begin
          state_d = pfe_pkg::SPowSq;
        end
      end
      pfe_pkg::SPowWait: begin
        if (alu_done) begin
          acc_d = alu_res;
          state_d = pfe_pkg::SPowSq;
        end
      end
      pfe_pkg::SPowSq: begin
        exp_d = exp_q >> 1;
        if (exp_d == '0) begin
          state_d = pfe_pkg::SPowMul;
        end else begin
          alu_ctl.start = 1'b1;
          alu_a = $signed(base_q);
          alu_b = $signed(base_q);
          state_d = pfe_pkg::SPowSqWait;
        end
      end
      pfe_pkg::SPowSqWait: begin
        if (alu_done) begin
          base_d = alu_res;
          state_d = pfe_pkg::SPowMul;
        end
      end
      pfe_pkg::SAluWait: begin
        if (alu_done) begin
          pv_d = alu_res;
          state_d = pfe_pkg::SPush;
        end
      end
      pfe_pkg::SPush: begin
        if (cnt_q >= CW'(pfe_pkg::StackDepth)) begin
          err_d = pfe_pkg::StFull;
        end else begin
          we = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
        state_d = pfe_pkg::SLast;
      end
      pfe_pkg::SLast: begin
        state_d = last_q ? pfe_pkg::SLastRd : pfe_pkg::SIdle;
      end
      pfe_pkg::SLastRd: begin
        state_d = pfe_pkg::SOut;
      end
      pfe_pkg::SOut: begin
        if (!vo_q || ready_i) begin
          vo_d = 1'b1;
          ov_d = 32'(rd_q);
          os_d = err_q;
          if (err_q != pfe_pkg::StOk) begin
            ov_d = '0;
          end else if (cnt_q == '0) begin
            ov_d = '0;
            os_d = pfe_pkg::StUnder;
          end
          cnt_d = '0;
          err_d = pfe_pkg::StOk;
          state_d = pfe_pkg::SIdle;
        end
      end
      default: state_d = pfe_pkg::SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfe_pkg::SIdle;
      cnt_q <= '0;
      err_q <= pfe_pkg::StOk;
      vo_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      err_q <= err_d;
      vo_q <= vo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
    last_q <= last_d;
    var_q <= var_d;
    l_q <= l_d;
    r_q <= r_d;
    base_q <= base_d;
    acc_q <= acc_d;
    exp_q <= exp_d;
    pv_q <= pv_d;
    ov_q <= ov_d;
    os_q <= os_d;
  end

  assign valid_o = vo_q;
  assign result_value_o = $signed(ov_q);
  assign status_o = os_q;
endmodule

@@ rtl/core/pfe_checker.sv @@
// Port-level checker for the postfix evaluator, bound to the top level.
// Depends on assert_macros.svh and pfe_pkg.
`include "assert_macros.svh"
module pfe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_o,
  input logic        valid_o,
  input logic        ready_i,
  input logic [31:0] result_value_o,
  input logic [2:0]  status_o
);
  `ASSERT_IMPL(a_status_range, clk_i, rst_ni, valid_o, status_o <= pfe_pkg::StNegExp)
  `ASSERT_IMPL(a_err_zero, clk_i, rst_ni, valid_o && status_o != pfe_pkg::StOk, result_value_o == 32'd0)
  `ASSERT_NEXT(a_value_hold, clk_i, rst_ni, valid_o && !ready_i, $stable(result_value_o))
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, valid_o && !ready_i, valid_o && $stable(status_o))
  `ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, valid_i && ready_o, !ready_o)
endmodule

bind postfix_expression_evaluator pfe_checker u_pfe_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .valid_i        (valid_i),
  .ready_o        (ready_o),
  .valid_o        (valid_o),
  .ready_i        (ready_i),
  .result_value_o (result_value_o),
  .status_o       (status_o)
);
